### hdl/mddc_pkg.sv
// ----------------------------------------------------------------------------
// mddc_pkg
// Shared types and codes for the disk controller register bank.
// ----------------------------------------------------------------------------
package mddc_pkg;

  localparam int DRIVE_COUNT = 8;
  localparam int DRV_IDX_W   = $clog2(DRIVE_COUNT);
  localparam int SEL_W       = 4;

  // bus access kind
  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  // register offsets
  localparam logic [3:0] OFF_SN_HI   = 4'd1;
  localparam logic [3:0] OFF_SN_MID  = 4'd2;
  localparam logic [3:0] OFF_SN_LO   = 4'd3;
  localparam logic [3:0] OFF_DMA_HI  = 4'd4;
  localparam logic [3:0] OFF_DMA_MID = 4'd5;
  localparam logic [3:0] OFF_DMA_LO  = 4'd6;
  localparam logic [3:0] OFF_COUNT   = 4'd7;
  localparam logic [3:0] OFF_STATUS  = 4'd8;

  // command bytes
  localparam logic [7:0] CMD_SEL_MAX   = 8'h0F;
  localparam logic [7:0] CMD_SIZE_0    = 8'h10;
  localparam logic [7:0] CMD_SIZE_1    = 8'h11;
  localparam logic [7:0] CMD_SIZE_2    = 8'h12;
  localparam logic [7:0] CMD_SIZE_3    = 8'h13;
  localparam logic [7:0] CMD_READ      = 8'h20;
  localparam logic [7:0] CMD_WRITE     = 8'h21;
  localparam logic [7:0] CMD_MOUNT     = 8'h22;
  localparam logic [7:0] CMD_UNMOUNT   = 8'h23;
  localparam logic [7:0] CMD_SEEK_LAST = 8'h24;
  localparam logic [7:0] CMD_SEEK_END  = 8'h25;
  localparam logic [7:0] CMD_SYNC      = 8'h26;
  localparam logic [7:0] CMD_CLR_ERR   = 8'h80;

  localparam logic [7:0] STATUS_MISSING = 8'h80;

  // per-drive reset values
  localparam logic [7:0] CNT_RST = 8'd1;
  localparam logic [1:0] SZ_RST  = 2'd2;
  localparam logic [3:0] LG_BASE = 4'd7;

  typedef struct packed {
    logic        command;
    logic [3:0]  reg_offset;
    logic [7:0]  write_data;
    logic        media_ok;
    logic [31:0] media_size_bytes;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        xfer_start;
    logic        xfer_is_write;
    logic [23:0] xfer_dma_address;
    logic [31:0] xfer_byte_offset;
    logic [17:0] xfer_byte_count;
  } out_word_t;

  typedef struct packed {
    logic cap;
    logic fetch;
    logic exec;
  } ctrl_cmd_t;

endpackage

### hdl/multi_drive_disk_controller_regs_top.sv
// An accepted word is captured, its drive entry fetched, then executed with the
//   result registered. busy holds off new words in the fetch and execute states,
//   set by the single read/modify/write pass over the selected drive entry.
// out_valid is a one-cycle strobe; the receiver cannot stall it.
// Reset (rst_n low, synchronous): drive 0 selected, every drive unmounted with
//   error set, count 1, 512-byte sectors, pointers and media size zero.
// ----------------------------------------------------------------------------
// multi_drive_disk_controller_regs_top
// Bus-side register bank of a multi-drive disk controller: byte registers,
// status, commands and validated transfer requests.
// ----------------------------------------------------------------------------
module multi_drive_disk_controller_regs_top
  import mddc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  // sequencer commands into the datapath
  ctrl_cmd_t cmd;

  // controller: idle -> fetch entry -> execute/write back
  mddc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // datapath: drive store, bound check, result register
  mddc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

### hdl/mddc_ctrl.sv
// ----------------------------------------------------------------------------
// mddc_ctrl
// Sequencer: capture word, fetch drive entry, execute and write back.
// ----------------------------------------------------------------------------
module mddc_ctrl
  import mddc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output ctrl_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_FETCH;
      ST_FETCH: state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign cmd.cap   = start && (state_r == ST_IDLE);
  assign cmd.fetch = (state_r == ST_FETCH);
  assign cmd.exec  = (state_r == ST_EXEC);

endmodule

### hdl/mddc_dp.sv
// ----------------------------------------------------------------------------
// mddc_dp
// Per-drive register file, transfer check and result register.
// ----------------------------------------------------------------------------
module mddc_dp
  import mddc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  ctrl_cmd_t cmd,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  logic [SEL_W-1:0] sel_r, sel_nxt;
  logic [31:0]      sn_r   [DRIVE_COUNT];
  logic [23:0]      dma_r  [DRIVE_COUNT];
  logic [7:0]       cnt_r  [DRIVE_COUNT];
  logic [1:0]       sz_r   [DRIVE_COUNT];
  logic [31:0]      msz_r  [DRIVE_COUNT];
  logic             mnt_r  [DRIVE_COUNT];
  logic             wrt_r  [DRIVE_COUNT];
  logic             err_r  [DRIVE_COUNT];

  in_word_t         in_r;
  logic [31:0]      st_r;
  logic [17:0]      by_r;
  logic [42:0]      sum_r;
  logic [31:0]      msh_r;
  out_word_t        out_r, out_nxt;
  logic             out_valid_r;

  logic [DRV_IDX_W-1:0] idx;
  logic                 present;
  logic [31:0]          cur_sn, cur_msz, sn_nxt, msz_nxt;
  logic [23:0]          cur_dma, dma_nxt;
  logic [7:0]           cur_cnt, cnt_nxt, rd_byte;
  logic [1:0]           cur_sz, sz_nxt;
  logic                 cur_mnt, cur_wrt, cur_err, mnt_nxt, wrt_nxt, err_nxt;
  logic [3:0]           lg;
  logic [41:0]          st_w;
  logic [17:0]          by_w;
  logic                 xfer_bad;

  assign idx     = sel_r[DRV_IDX_W-1:0];
  assign present = ({1'b0, sel_r} < (SEL_W + 1)'(DRIVE_COUNT));
  assign cur_sn  = sn_r[idx];
  assign cur_dma = dma_r[idx];
  assign cur_cnt = cnt_r[idx];
  assign cur_sz  = sz_r[idx];
  assign cur_msz = msz_r[idx];
  assign cur_mnt = mnt_r[idx];
  assign cur_wrt = wrt_r[idx];
  assign cur_err = err_r[idx];

  // sector size log2: 7..10
  assign lg   = {2'b00, cur_sz} + LG_BASE;
  assign st_w = 42'(cur_sn) << lg;
  assign by_w = 18'(cur_cnt) << lg;

  // fetch stage: shifted pointers and bound sum
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      in_r <= in_word;
    end
    if (cmd.fetch) begin
      st_r  <= st_w[31:0];
      by_r  <= by_w;
      sum_r <= {1'b0, st_w} + 43'(by_w);
      msh_r <= cur_msz >> lg;
    end
  end

  // register read mux
  always_comb begin
    rd_byte = '0;
    if (in_r.reg_offset == OFF_STATUS) begin
      rd_byte = present ? {cur_err, cur_wrt, cur_sz, sel_r} : STATUS_MISSING;
    end else if (present) begin
      case (in_r.reg_offset)
        OFF_SN_HI:   rd_byte = cur_sn[23:16];
        OFF_SN_MID:  rd_byte = cur_sn[15:8];
        OFF_SN_LO:   rd_byte = cur_sn[7:0];
        OFF_DMA_HI:  rd_byte = cur_dma[23:16];
        OFF_DMA_MID: rd_byte = cur_dma[15:8];
        OFF_DMA_LO:  rd_byte = cur_dma[7:0];
        OFF_COUNT:   rd_byte = cur_cnt;
        default:     rd_byte = '0;
      endcase
    end
  end

  assign xfer_bad = !cur_mnt
                 || ((in_r.write_data == CMD_WRITE) && !cur_wrt)
                 || (sum_r > {11'b0, cur_msz})
                 || !in_r.media_ok;

  // execute stage: next entry values and result
  always_comb begin
    sel_nxt = sel_r;
    sn_nxt  = cur_sn;
    dma_nxt = cur_dma;
    cnt_nxt = cur_cnt;
    sz_nxt  = cur_sz;
    msz_nxt = cur_msz;
    mnt_nxt = cur_mnt;
    wrt_nxt = cur_wrt;
    err_nxt = cur_err;
    out_nxt = '0;
    if (in_r.command == ACC_READ) begin
      out_nxt.read_data = rd_byte;
    end else if (in_r.reg_offset == OFF_STATUS) begin
      if (in_r.write_data <= CMD_SEL_MAX) begin
        sel_nxt = in_r.write_data[SEL_W-1:0];
      end else if (present) begin
        unique case (in_r.write_data) inside
          CMD_SIZE_0, CMD_SIZE_1, CMD_SIZE_2, CMD_SIZE_3: begin
            sz_nxt = in_r.write_data[1:0];
          end
          CMD_READ, CMD_WRITE: begin
            if (xfer_bad) begin
              err_nxt = 1'b1;
            end else begin
              out_nxt.xfer_start       = 1'b1;
              out_nxt.xfer_is_write    = (in_r.write_data == CMD_WRITE);
              out_nxt.xfer_dma_address = cur_dma;
              out_nxt.xfer_byte_offset = st_r;
              out_nxt.xfer_byte_count  = by_r;
              dma_nxt = cur_dma + {6'b0, by_r};
              sn_nxt  = cur_sn + 32'(cur_cnt);
            end
          end
          CMD_MOUNT: begin
            sn_nxt  = '0;
            err_nxt = !in_r.media_ok;
            mnt_nxt = in_r.media_ok;
            wrt_nxt = in_r.media_ok;
            msz_nxt = in_r.media_ok ? in_r.media_size_bytes : '0;
          end
          CMD_UNMOUNT: begin
            mnt_nxt = 1'b0;
            wrt_nxt = 1'b0;
            err_nxt = 1'b1;
            msz_nxt = '0;
          end
          CMD_SEEK_LAST: sn_nxt  = msh_r - 32'd1;
          CMD_SEEK_END:  sn_nxt  = msh_r;
          CMD_CLR_ERR:   err_nxt = !cur_mnt;
          CMD_SYNC:      ;
          default:       ;
        endcase
      end
    end else if (present) begin
      case (in_r.reg_offset)
        OFF_SN_HI:   sn_nxt[23:16]  = in_r.write_data;
        OFF_SN_MID:  sn_nxt[15:8]   = in_r.write_data;
        OFF_SN_LO:   sn_nxt[7:0]    = in_r.write_data;
        OFF_DMA_HI:  dma_nxt[23:16] = in_r.write_data;
        OFF_DMA_MID: dma_nxt[15:8]  = in_r.write_data;
        OFF_DMA_LO:  dma_nxt[7:0]   = in_r.write_data;
        OFF_COUNT:   cnt_nxt        = in_r.write_data;
        default:     ;
      endcase
    end
  end

  // drive entries; a missing drive writes back unchanged values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= '0;
      for (int i = 0; i < DRIVE_COUNT; i++) begin
        sn_r[i]  <= '0;
        dma_r[i] <= '0;
        cnt_r[i] <= CNT_RST;
        sz_r[i]  <= SZ_RST;
        msz_r[i] <= '0;
        mnt_r[i] <= 1'b0;
        wrt_r[i] <= 1'b0;
        err_r[i] <= 1'b1;
      end
    end else if (cmd.exec) begin
      sel_r      <= sel_nxt;
      sn_r[idx]  <= sn_nxt;
      dma_r[idx] <= dma_nxt;
      cnt_r[idx] <= cnt_nxt;
      sz_r[idx]  <= sz_nxt;
      msz_r[idx] <= msz_nxt;
      mnt_r[idx] <= mnt_nxt;
      wrt_r[idx] <= wrt_nxt;
      err_r[idx] <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.exec;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

### hdl/mddc_chk.sv
// ----------------------------------------------------------------------------
// mddc_chk
// Port-level checks on the register bank, bound to the top level.
// ----------------------------------------------------------------------------
module mddc_chk
  import mddc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_word_t  in_word,
  input logic      out_valid,
  input out_word_t out_word
);

  // every accepted word is followed by a result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("result strobe missing after accepted word");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted word");

  a_no_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result strobe while busy");

  a_write_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_word.command, 3) == ACC_WRITE)) |-> (out_word.read_data == '0))
    else $error("read data nonzero on write access");

  a_idle_xfer_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.xfer_start) |->
      (!out_word.xfer_is_write && (out_word.xfer_dma_address == '0) &&
       (out_word.xfer_byte_offset == '0) && (out_word.xfer_byte_count == '0)))
    else $error("transfer fields nonzero without transfer");

endmodule

bind multi_drive_disk_controller_regs_top mddc_chk u_mddc_chk (.*);

### verif/mddc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mddc_checker
// Watches the bus word and result channels of the disk controller register
// bank, predicts every result from its own copy of the drive state and
// compares the results field by field in order.
// ----------------------------------------------------------------------------
module mddc_checker
  import mddc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  out_word_t out_word,
  output int        fail_count,
  output int        pending,
  output int        xfer_count
);

  logic [SEL_W-1:0] cur_drive;
  logic [31:0]      sector_no   [DRIVE_COUNT];
  logic [23:0]      dma_addr    [DRIVE_COUNT];
  logic [7:0]       sec_cnt     [DRIVE_COUNT];
  logic [1:0]       size_code   [DRIVE_COUNT];
  logic [31:0]      media_bytes [DRIVE_COUNT];
  logic             mounted     [DRIVE_COUNT];
  logic             writable    [DRIVE_COUNT];
  logic             err_flag    [DRIVE_COUNT];

  out_word_t expected_q [$];
  int        fails;
  int        xfers;

  function automatic out_word_t predict_access(input in_word_t w);
    out_word_t   r;
    int          d;
    int          lg;
    logic        present;
    logic        is_wr;
    logic [63:0] first_byte;
    logic [63:0] nbytes;
    r       = '0;
    d       = int'(cur_drive);
    present = (d < DRIVE_COUNT);
    if (w.command == ACC_READ) begin
      if (w.reg_offset == OFF_STATUS) begin
        if (present)
          r.read_data = {err_flag[d], writable[d], size_code[d], cur_drive};
        else
          r.read_data = STATUS_MISSING;
      end else if (present) begin
        case (w.reg_offset)
          OFF_SN_HI:   r.read_data = sector_no[d][23:16];
          OFF_SN_MID:  r.read_data = sector_no[d][15:8];
          OFF_SN_LO:   r.read_data = sector_no[d][7:0];
          OFF_DMA_HI:  r.read_data = dma_addr[d][23:16];
          OFF_DMA_MID: r.read_data = dma_addr[d][15:8];
          OFF_DMA_LO:  r.read_data = dma_addr[d][7:0];
          OFF_COUNT:   r.read_data = sec_cnt[d];
          default:     r.read_data = '0;
        endcase
      end
      return r;
    end

    if (w.reg_offset == OFF_STATUS) begin
      if (w.write_data <= CMD_SEL_MAX) begin
        cur_drive = w.write_data[SEL_W-1:0];
      end else if (present) begin
        lg = int'(size_code[d]) + int'(LG_BASE);
        case (w.write_data)
          // low two bits of the size commands are the code itself
          CMD_SIZE_0, CMD_SIZE_1, CMD_SIZE_2, CMD_SIZE_3: begin
            size_code[d] = w.write_data[1:0];
          end
          CMD_READ, CMD_WRITE: begin
            is_wr      = (w.write_data == CMD_WRITE);
            first_byte = {32'd0, sector_no[d]} << lg;
            nbytes     = {56'd0, sec_cnt[d]} << lg;
            // 64-bit sum: the bound check must not wrap
            if (!mounted[d] || (is_wr && !writable[d]) || !w.media_ok ||
                (first_byte + nbytes > {32'd0, media_bytes[d]})) begin
              err_flag[d] = 1'b1;
            end else begin
              r.xfer_start       = 1'b1;
              r.xfer_is_write    = is_wr;
              r.xfer_dma_address = dma_addr[d];
              r.xfer_byte_offset = first_byte[31:0];
              r.xfer_byte_count  = nbytes[17:0];
              dma_addr[d]        = dma_addr[d] + nbytes[23:0];
              sector_no[d]       = sector_no[d] + {24'd0, sec_cnt[d]};
            end
          end
          CMD_MOUNT: begin
            sector_no[d]   = '0;
            err_flag[d]    = !w.media_ok;
            mounted[d]     = w.media_ok;
            writable[d]    = w.media_ok;
            media_bytes[d] = w.media_ok ? w.media_size_bytes : 32'd0;
          end
          CMD_UNMOUNT: begin
            mounted[d]     = 1'b0;
            writable[d]    = 1'b0;
            err_flag[d]    = 1'b1;
            media_bytes[d] = '0;
          end
          CMD_SEEK_LAST: sector_no[d] = (media_bytes[d] >> lg) - 32'd1;
          CMD_SEEK_END:  sector_no[d] = media_bytes[d] >> lg;
          CMD_CLR_ERR:   err_flag[d]  = !mounted[d];
          default: ;  // sync and unknown codes leave the state alone
        endcase
      end
    end else if (present) begin
      case (w.reg_offset)
        OFF_SN_HI:   sector_no[d][23:16] = w.write_data;
        OFF_SN_MID:  sector_no[d][15:8]  = w.write_data;
        OFF_SN_LO:   sector_no[d][7:0]   = w.write_data;
        OFF_DMA_HI:  dma_addr[d][23:16]  = w.write_data;
        OFF_DMA_MID: dma_addr[d][15:8]   = w.write_data;
        OFF_DMA_LO:  dma_addr[d][7:0]    = w.write_data;
        OFF_COUNT:   sec_cnt[d]          = w.write_data;
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      cur_drive = '0;
      for (int i = 0; i < DRIVE_COUNT; i++) begin
        sector_no[i]   = '0;
        dma_addr[i]    = '0;
        sec_cnt[i]     = CNT_RST;
        size_code[i]   = SZ_RST;
        media_bytes[i] = '0;
        mounted[i]     = 1'b0;
        writable[i]    = 1'b0;
        err_flag[i]    = 1'b1;
      end
      expected_q.delete();
      fails = 0;
      xfers = 0;
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_word);
          fails++;
        end else begin
          want = expected_q.pop_front();
          check_field("read_data", 32'(want.read_data), 32'(out_word.read_data));
          check_field("xfer_start", 32'(want.xfer_start), 32'(out_word.xfer_start));
          check_field("xfer_is_write", 32'(want.xfer_is_write),
                      32'(out_word.xfer_is_write));
          check_field("xfer_dma_address", 32'(want.xfer_dma_address),
                      32'(out_word.xfer_dma_address));
          check_field("xfer_byte_offset", want.xfer_byte_offset,
                      out_word.xfer_byte_offset);
          check_field("xfer_byte_count", 32'(want.xfer_byte_count),
                      32'(out_word.xfer_byte_count));
        end
      end
      if (start && !busy) begin
        want = predict_access(in_word);
        if (want.xfer_start)
          xfers++;
        expected_q.push_back(want);
      end
    end
    fail_count <= fails;
    xfer_count <= xfers;
    pending    <= expected_q.size();
  end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Bus-side stimulus for the disk controller register bank: a directed walk
// through status, byte registers, every command and the transfer checks,
// then weighted random bus words with idle bursts and a full drain.
// ----------------------------------------------------------------------------
module tb_top;
  import mddc_pkg::*;

  // offsets and codes with no name in the package
  localparam logic [3:0] OFF_RSVD_LO = 4'd0;
  localparam logic [3:0] OFF_RSVD_HI = 4'd15;
  localparam logic [7:0] CMD_SEL_0   = 8'h00;
  localparam logic [7:0] CMD_UNKNOWN = 8'h7F;
  localparam int         RAND_WORDS  = 600;
  localparam int         QUIET_TAIL  = 100;  // last random words sent with no random idle bursts

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_valid;
  out_word_t out_word;

  int fail_count;
  int pending;
  int xfer_count;
  int words_sent;

  always #1 clk = ~clk;

  multi_drive_disk_controller_regs_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  mddc_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_word   (out_word),
    .fail_count (fail_count),
    .pending    (pending),
    .xfer_count (xfer_count)
  );

  // Present one word and hold it until the edge that takes it (start high,
  // busy low). start stays high afterwards, so back-to-back words never
  // see it dropped and raised in the same step.
  task automatic send_word(input in_word_t w);
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  task automatic access(input logic kind, input logic [3:0] off, input logic [7:0] data,
                        input logic ok = 1'b1, input logic [31:0] size = 32'd0);
    in_word_t w;
    w = '{kind, off, data, ok, size};
    send_word(w);
  endtask

  // Drop start and wait until the checker holds no open result.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Weighted random word: mostly well-formed commands and register traffic
  // so that drives get mounted and transfers pass, plus raw noise.
  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    w.command    = 1'($urandom_range(0, 1));
    w.reg_offset = 4'($urandom_range(0, 15));
    w.write_data = 8'($urandom);
    w.media_ok   = ($urandom_range(0, 9) != 0);
    case ($urandom_range(0, 3))
      0:       w.media_size_bytes = $urandom;
      1:       w.media_size_bytes = $urandom_range(0, 1 << 20);
      2:       w.media_size_bytes = 32'hFFFF_FFFF;
      default: w.media_size_bytes = $urandom_range(0, 8191) << 9;
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      w.command    = ACC_WRITE;
      w.reg_offset = OFF_STATUS;
      case ($urandom_range(0, 12))
        0: begin
          // mostly present drives, now and then a missing one
          if ($urandom_range(0, 9) == 0)
            w.write_data = 8'($urandom_range(DRIVE_COUNT, CMD_SEL_MAX));
          else
            w.write_data = 8'($urandom_range(0, DRIVE_COUNT - 1));
        end
        1:     w.write_data = CMD_SIZE_0 + 8'($urandom_range(0, 3));
        2, 3:  w.write_data = CMD_READ;
        4, 5:  w.write_data = CMD_WRITE;
        6, 7:  w.write_data = CMD_MOUNT;
        8:     w.write_data = CMD_UNMOUNT;
        9:     w.write_data = $urandom_range(0, 1) ? CMD_SEEK_LAST : CMD_SEEK_END;
        10:    w.write_data = $urandom_range(0, 1) ? CMD_CLR_ERR : CMD_SYNC;
        default: ;  // any byte, unknown codes included
      endcase
    end else if (pick < 65) begin
      w.command    = ACC_WRITE;
      w.reg_offset = 4'($urandom_range(OFF_SN_HI, OFF_COUNT));
      // keep pointers and counts small often enough for transfers to fit
      if ($urandom_range(0, 1) == 0)
        w.write_data = (w.reg_offset == OFF_COUNT) ? 8'($urandom_range(0, 16)) :
                                                     8'($urandom_range(0, 3));
    end else if (pick < 90) begin
      w.command = ACC_READ;
    end
    return w;
  endfunction

  // Hard stop well past the slowest correct run.
  initial begin
    #400000;
    $display("multi_drive_disk_controller_regs_top verification failed");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_word    = '0;
    words_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // reset status, reserved offsets
    access(ACC_READ,  OFF_STATUS,  8'h00);
    access(ACC_WRITE, OFF_RSVD_LO, 8'hFF);
    access(ACC_READ,  OFF_RSVD_LO, 8'h00);
    access(ACC_WRITE, OFF_RSVD_HI, 8'hFF);
    access(ACC_READ,  OFF_RSVD_HI, 8'h00);
    // transfer on an unmounted drive, failed mount, full-size mount
    access(ACC_WRITE, OFF_STATUS, CMD_READ);
    access(ACC_WRITE, OFF_STATUS, CMD_MOUNT, 1'b0, 32'hFFFF_FFFF);
    access(ACC_WRITE, OFF_STATUS, CMD_MOUNT, 1'b1, 32'hFFFF_FFFF);
    // DMA pointer at its top so the advance wraps
    access(ACC_WRITE, OFF_DMA_HI,  8'hFF);
    access(ACC_WRITE, OFF_DMA_MID, 8'hFF);
    access(ACC_WRITE, OFF_DMA_LO,  8'hFF);
    // 1 KiB sectors, park on the last one; a full count runs past 4 GiB,
    // which the bound check has to catch without wrapping
    access(ACC_WRITE, OFF_STATUS, CMD_SIZE_3);
    access(ACC_WRITE, OFF_STATUS, CMD_SEEK_LAST);
    access(ACC_WRITE, OFF_COUNT,  8'hFF);
    access(ACC_WRITE, OFF_STATUS, CMD_WRITE);
    // one sector fits, but the host seek fails first
    access(ACC_WRITE, OFF_COUNT,  8'h01);
    access(ACC_WRITE, OFF_STATUS, CMD_WRITE, 1'b0);
    access(ACC_WRITE, OFF_STATUS, CMD_CLR_ERR);
    access(ACC_WRITE, OFF_STATUS, CMD_WRITE);
    access(ACC_READ,  OFF_DMA_LO, 8'h00);
    // zero count still starts a transfer
    access(ACC_WRITE, OFF_COUNT,  8'h00);
    access(ACC_WRITE, OFF_STATUS, CMD_READ);
    access(ACC_WRITE, OFF_STATUS, CMD_SEEK_END);
    access(ACC_WRITE, OFF_STATUS, CMD_SYNC);
    access(ACC_WRITE, OFF_STATUS, CMD_UNKNOWN);
    access(ACC_READ,  OFF_SN_HI,  8'h00);
    // unmount, then a write to a drive that is neither mounted nor writable
    access(ACC_WRITE, OFF_STATUS, CMD_UNMOUNT);
    access(ACC_WRITE, OFF_STATUS, CMD_WRITE);
    // missing drive: status 0x80, registers dead, only selects act
    access(ACC_WRITE, OFF_STATUS, CMD_SEL_MAX);
    access(ACC_READ,  OFF_STATUS, 8'h00);
    access(ACC_WRITE, OFF_COUNT,  8'h55);
    access(ACC_WRITE, OFF_STATUS, CMD_MOUNT, 1'b1, 32'h0010_0000);
    access(ACC_READ,  OFF_COUNT,  8'h00);
    access(ACC_WRITE, OFF_STATUS, CMD_SEL_0);

    // ---- random part ----
    for (int i = 0; i < RAND_WORDS; i++) begin
      if (i % 200 == 100) begin
        drain();  // sender waits out every open result
      end else if (i < RAND_WORDS - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      send_word(random_word());
    end

    // wait out the tail, then leave room for stray results
    drain();
    repeat (10) @(posedge clk);

    $display("Run covered %0d bus words over all offsets, commands and a missing drive;",
             words_sent);
    $display("%0d transfer requests were predicted along the way.", xfer_count);
    if (fail_count == 0 && pending == 0) begin
      $display("multi_drive_disk_controller_regs_top verification clean");
    end else begin
      $display("multi_drive_disk_controller_regs_top verification failed");
    end
    $finish;
  end

endmodule
